### hw/rtl/pixel_temporal_iir_bandpass_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pixel temporal bandpass
// Shared concurrent property forms, clocked on the rising edge and held off
// while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TEMPORAL_IIR_BANDPASS_ASSERT_SVH
`define PIXEL_TEMPORAL_IIR_BANDPASS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTIB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pixel bandpass property failed");

// Consequent must hold in the cycle after the antecedent.
`define PTIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pixel bandpass property failed");

`endif

### hw/rtl/ptib_pkg.sv
// ----------------------------------------------------------------------------
// Pixel temporal bandpass package
// Field widths, register codes, reset values and the lane control bundle.
// ----------------------------------------------------------------------------
package ptib_pkg;

    localparam int INDEX_W     = 14;
    localparam int SAMPLE_W    = 8;
    localparam int CUTOFF_W    = 16;
    localparam int BAND_W      = 25;
    localparam int NUM_CH      = 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CUTOFF_W-1:0] CUTOFF_FAST_RESET = 16'd26214;
    localparam logic [CUTOFF_W-1:0] CUTOFF_SLOW_RESET = 16'd3277;
    // About 0.01 in Q0.16; used whenever the slow cutoff is written as zero.
    localparam logic [CUTOFF_W-1:0] SLOW_CUTOFF_FLOOR = 16'd655;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CUTOFF_FAST = 2'd0,
        REG_CUTOFF_SLOW = 2'd1
    } t_cfg_reg;

    // Per-cycle control that the top level hands to each channel lane.
    typedef struct packed {
        logic en_front;  // input, reduce and read stages advance
        logic en_pipe;   // multiply-result and update stages advance
        logic wr_en;     // update stage writes its new state back
        logic fwd;       // last update stage holds the location being read
        logic prime_d;   // update stage item loads the sample directly
    } t_lane_ctrl;

endpackage

### hw/rtl/ptib_cfg_regs.sv
// ----------------------------------------------------------------------------
// Cutoff configuration registers
// Holds the fast and slow Q0.16 cutoffs; a zero slow cutoff is stored as the
// floor value so the datapath never sees it.
// ----------------------------------------------------------------------------
module ptib_cfg_regs
    import ptib_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CUTOFF_W-1:0]    i_cfg_data,
    output logic [CUTOFF_W-1:0]    o_cutoff_fast,
    output logic [CUTOFF_W-1:0]    o_cutoff_slow
);

    logic [CUTOFF_W-1:0] r_cutoff_fast;
    logic [CUTOFF_W-1:0] r_cutoff_slow;
    logic [CUTOFF_W-1:0] n_cutoff_slow;

    // Writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Replace a zero slow cutoff by the floor value at write time.
    assign n_cutoff_slow = (i_cfg_data == '0) ? SLOW_CUTOFF_FLOOR : i_cfg_data;

    // Register decode; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff_fast <= CUTOFF_FAST_RESET;
            r_cutoff_slow <= CUTOFF_SLOW_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CUTOFF_FAST: r_cutoff_fast <= i_cfg_data;
                REG_CUTOFF_SLOW: r_cutoff_slow <= n_cutoff_slow;
                default: ;
            endcase
        end
    end

    assign o_cutoff_fast = r_cutoff_fast;
    assign o_cutoff_slow = r_cutoff_slow;

endmodule

### hw/rtl/ptib_index_mod.sv
// ----------------------------------------------------------------------------
// Pixel location reduction
// Two register stages that reduce the pixel index modulo a smaller frame size
// by a reciprocal multiply, a back-multiply and one correcting subtract.
// ----------------------------------------------------------------------------
module ptib_index_mod
    import ptib_pkg::*;
#(
    parameter int FRAME_PIXELS = 16384,
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [INDEX_W-1:0] i_index,
    output logic [AW-1:0]      o_loc
);

    logic [AW-1:0] r_b_loc;

    if (FRAME_PIXELS < (1 << INDEX_W)) begin : g_mod
        localparam int RK = 2 * INDEX_W;
        localparam longint unsigned RECIP_L = (64'd1 << RK) / FRAME_PIXELS;
        localparam logic [RK:0] RECIP = RECIP_L[RK:0];
        localparam logic [INDEX_W:0] MODULUS = (INDEX_W + 1)'(FRAME_PIXELS);

        logic [INDEX_W+RK:0]  prod;
        logic [INDEX_W-1:0]   r_a_q;
        logic [INDEX_W-1:0]   r_a_idx;
        logic [2*INDEX_W:0]   qn;
        logic [INDEX_W:0]     rem;
        logic [INDEX_W:0]     rem_fix;

        // First stage: quotient estimate, exact or one too small.
        assign prod = (INDEX_W + RK + 1)'(i_index) * (INDEX_W + RK + 1)'(RECIP);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_q   <= prod[RK +: INDEX_W];
                r_a_idx <= i_index;
            end
        end

        // Second stage: remainder with a single correction step.
        assign qn      = (2 * INDEX_W + 1)'(r_a_q) * (2 * INDEX_W + 1)'(MODULUS);
        assign rem     = (INDEX_W + 1)'({{(INDEX_W + 1){1'b0}}, r_a_idx} - qn);
        assign rem_fix = (rem >= MODULUS) ? (rem - MODULUS) : rem;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_b_loc <= rem_fix[AW-1:0];
            end
        end
    end else begin : g_pass
        logic [INDEX_W-1:0] r_a_idx;

        // The frame covers every index: location is the index itself.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_idx <= i_index;
                r_b_loc <= AW'(r_a_idx);
            end
        end
    end

    assign o_loc = r_b_loc;

endmodule

### hw/rtl/ptib_lane.sv
// ----------------------------------------------------------------------------
// Channel lane
// Fast and slow state memories of one channel with the read, multiply,
// update and difference stages of the low-pass pair.
// ----------------------------------------------------------------------------
module ptib_lane
    import ptib_pkg::*;
#(
    parameter int FRAME_PIXELS  = 16384,
    parameter int FRACTION_BITS = 16,
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
    input  logic                     i_clk,
    input  t_lane_ctrl               i_ctrl,
    input  logic [SAMPLE_W-1:0]      i_sample,
    input  logic [AW-1:0]            i_rd_addr,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [CUTOFF_W-1:0]      i_cutoff_fast,
    input  logic [CUTOFF_W-1:0]      i_cutoff_slow,
    output logic signed [BAND_W-1:0] o_band
);

    localparam int SW = SAMPLE_W + FRACTION_BITS;           // state width
    localparam int PW = SW + CUTOFF_W + 2;                  // product width
    localparam int DW = (SW + 1 > BAND_W) ? SW + 1 : BAND_W;

    logic [SW-1:0] mem_fast [FRAME_PIXELS];
    logic [SW-1:0] mem_slow [FRAME_PIXELS];

    logic [SAMPLE_W-1:0]  r_a_smp;
    logic [SAMPLE_W-1:0]  r_b_smp;
    logic [SW-1:0]        r_c_tgt;
    logic [SW-1:0]        r_c_rd_fast;
    logic [SW-1:0]        r_c_rd_slow;
    logic [SW-1:0]        lp_fast;
    logic [SW-1:0]        lp_slow;
    logic signed [SW:0]   diff_fast;
    logic signed [SW:0]   diff_slow;
    logic signed [PW-1:0] prod_fast;
    logic signed [PW-1:0] prod_slow;
    logic signed [PW-1:0] r_d_prod_fast;
    logic signed [PW-1:0] r_d_prod_slow;
    logic [SW-1:0]        r_d_lp_fast;
    logic [SW-1:0]        r_d_lp_slow;
    logic [SW-1:0]        r_d_tgt;
    logic signed [SW+1:0] sum_fast;
    logic signed [SW+1:0] sum_slow;
    logic [SW-1:0]        nv_fast;
    logic [SW-1:0]        nv_slow;
    logic [SW-1:0]        r_e_fast;
    logic [SW-1:0]        r_e_slow;
    logic [DW-1:0]        band_diff;

    // Sample travels alongside the location reduction.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_front) begin
            r_a_smp <= i_sample;
            r_b_smp <= r_a_smp;
            r_c_tgt <= {r_b_smp, FRACTION_BITS'(0)};
        end
    end

    // State read, registered.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_front) begin
            r_c_rd_fast <= mem_fast[i_rd_addr];
            r_c_rd_slow <= mem_slow[i_rd_addr];
        end
    end

    // Take the newest state: the just-updated value when the read missed it.
    assign lp_fast = i_ctrl.fwd ? r_e_fast : r_c_rd_fast;
    assign lp_slow = i_ctrl.fwd ? r_e_slow : r_c_rd_slow;

    // Weighted step toward the sample.
    assign diff_fast = $signed({1'b0, r_c_tgt}) - $signed({1'b0, lp_fast});
    assign diff_slow = $signed({1'b0, r_c_tgt}) - $signed({1'b0, lp_slow});
    assign prod_fast = PW'(diff_fast) * PW'($signed({1'b0, i_cutoff_fast}));
    assign prod_slow = PW'(diff_slow) * PW'($signed({1'b0, i_cutoff_slow}));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_pipe) begin
            r_d_prod_fast <= prod_fast;
            r_d_prod_slow <= prod_slow;
            r_d_lp_fast   <= lp_fast;
            r_d_lp_slow   <= lp_slow;
            r_d_tgt       <= r_c_tgt;
        end
    end

    // Floor the product, add to the old state and clamp to the state range.
    assign sum_fast = $signed({2'b00, r_d_lp_fast}) + $signed(r_d_prod_fast[PW-1:CUTOFF_W]);
    assign sum_slow = $signed({2'b00, r_d_lp_slow}) + $signed(r_d_prod_slow[PW-1:CUTOFF_W]);

    always_comb begin
        if (i_ctrl.prime_d) begin
            nv_fast = r_d_tgt;
            nv_slow = r_d_tgt;
        end else begin
            nv_fast = sum_fast[SW+1] ? '0 : (sum_fast[SW] ? '1 : sum_fast[SW-1:0]);
            nv_slow = sum_slow[SW+1] ? '0 : (sum_slow[SW] ? '1 : sum_slow[SW-1:0]);
        end
    end

    // State write-back.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem_fast[i_wr_addr] <= nv_fast;
            mem_slow[i_wr_addr] <= nv_slow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_pipe) begin
            r_e_fast <= nv_fast;
            r_e_slow <= nv_slow;
        end
    end

    // Bandpass value is fast minus slow, kept to the band width.
    assign band_diff = DW'(r_e_fast) - DW'(r_e_slow);
    assign o_band    = band_diff[BAND_W-1:0];

endmodule

### hw/rtl/pixel_temporal_iir_bandpass.sv
// ----------------------------------------------------------------------------
// Pixel temporal IIR bandpass
// Usage: each input item carries a pixel location, a prime flag and three
// 8-bit channel samples; each result item carries the location and three
// signed fast-minus-slow low-pass values in Q8.FRACTION_BITS.
// Channels: input and result use valid/ready; the cutoff registers are
// written through a separate valid/ready port that is always ready.
// Path: an accepted item passes the input, reduce, read, multiply-result,
// update and output registers in that order. Throughput: one item per cycle
// while the receiver keeps up; an item whose location equals that of the
// item directly ahead of it waits, because the state update (subtract,
// multiply, add) of the earlier item must finish in the update stage before the later one can be multiplied.
// Reset: clears all pipeline valid bits and restores the default cutoffs.
// The state memories are not cleared; each location is to be primed first.
// Stall: when the receiver holds off, the result stays in the output
// register, one more item moves up behind it, and then the pipeline freezes
// as a whole with nothing lost or repeated.
// ----------------------------------------------------------------------------
`include "pixel_temporal_iir_bandpass_assert.svh"

module pixel_temporal_iir_bandpass
    import ptib_pkg::*;
#(
    parameter int FRAME_PIXELS  = 16384,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Input items
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [INDEX_W-1:0]       i_pixel_index,
    input  logic                     i_prime,
    input  logic [SAMPLE_W-1:0]      i_sample_ch0,
    input  logic [SAMPLE_W-1:0]      i_sample_ch1,
    input  logic [SAMPLE_W-1:0]      i_sample_ch2,
    // Result items
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [INDEX_W-1:0]       o_out_index,
    output logic signed [BAND_W-1:0] o_band_ch0,
    output logic signed [BAND_W-1:0] o_band_ch1,
    output logic signed [BAND_W-1:0] o_band_ch2,
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [CUTOFF_W-1:0]      i_cfg_data
);

    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    logic [CUTOFF_W-1:0] cutoff_fast;
    logic [CUTOFF_W-1:0] cutoff_slow;

    logic out_free;
    logic en_pipe;
    logic en_front;
    logic hazard;
    logic fwd;
    t_lane_ctrl lane_ctrl;

    logic r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_o_v;
    logic r_a_prime, r_b_prime, r_c_prime, r_d_prime;
    logic [INDEX_W-1:0] r_a_idx, r_b_idx, r_c_idx, r_d_idx, r_e_idx, r_o_idx;
    logic [AW-1:0] loc_b;
    logic [AW-1:0] r_c_loc, r_d_loc, r_e_loc;

    logic [SAMPLE_W-1:0]      smp       [NUM_CH];
    logic signed [BAND_W-1:0] lane_band [NUM_CH];
    logic signed [BAND_W-1:0] r_o_band  [NUM_CH];

    // Cutoff registers.
    ptib_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cutoff_fast (cutoff_fast),
        .o_cutoff_slow (cutoff_slow)
    );

    // Pipeline control: the output register frees the back, a same-location
    // pair in the read and update stages holds the front.
    assign out_free = !r_o_v || i_ready;
    assign en_pipe  = out_free || !r_e_v;
    assign hazard   = r_c_v && r_d_v && (r_c_loc == r_d_loc);
    assign en_front = en_pipe && !hazard;
    assign fwd      = r_e_v && (r_e_loc == r_c_loc);
    assign o_ready  = en_front;

    assign lane_ctrl.en_front = en_front;
    assign lane_ctrl.en_pipe  = en_pipe;
    assign lane_ctrl.wr_en    = en_pipe && r_d_v;
    assign lane_ctrl.fwd      = fwd;
    assign lane_ctrl.prime_d  = r_d_prime;

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (en_front) begin
                r_a_v <= i_valid;
                r_b_v <= r_a_v;
                r_c_v <= r_b_v;
            end
            if (en_pipe) begin
                r_d_v <= r_c_v && !hazard;
                r_e_v <= r_d_v;
            end
            if (out_free) begin
                r_o_v <= r_e_v;
            end
        end
    end

    // Item side data travelling with the valid bits.
    always_ff @(posedge i_clk) begin
        if (en_front) begin
            r_a_idx   <= i_pixel_index;
            r_b_idx   <= r_a_idx;
            r_c_idx   <= r_b_idx;
            r_a_prime <= i_prime;
            r_b_prime <= r_a_prime;
            r_c_prime <= r_b_prime;
            r_c_loc   <= loc_b;
        end
        if (en_pipe) begin
            r_d_idx   <= r_c_idx;
            r_e_idx   <= r_d_idx;
            r_d_prime <= r_c_prime;
            r_d_loc   <= r_c_loc;
            r_e_loc   <= r_d_loc;
        end
    end

    // Location reduction in the first two stages.
    ptib_index_mod #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_index_mod (
        .i_clk   (i_clk),
        .i_en    (en_front),
        .i_index (i_pixel_index),
        .o_loc   (loc_b)
    );

    assign smp[0] = i_sample_ch0;
    assign smp[1] = i_sample_ch1;
    assign smp[2] = i_sample_ch2;

    // One lane per channel.
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        ptib_lane #(
            .FRAME_PIXELS  (FRAME_PIXELS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_lane (
            .i_clk         (i_clk),
            .i_ctrl        (lane_ctrl),
            .i_sample      (smp[ch]),
            .i_rd_addr     (loc_b),
            .i_wr_addr     (r_d_loc),
            .i_cutoff_fast (cutoff_fast),
            .i_cutoff_slow (cutoff_slow),
            .o_band        (lane_band[ch])
        );
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_o_idx <= r_e_idx;
            for (int k = 0; k < NUM_CH; k++) begin
                r_o_band[k] <= lane_band[k];
            end
        end
    end

    assign o_valid     = r_o_v;
    assign o_out_index = r_o_idx;
    assign o_band_ch0  = r_o_band[0];
    assign o_band_ch1  = r_o_band[1];
    assign o_band_ch2  = r_o_band[2];

    // An accepted item shows up in the first stage.
    `PTIB_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_a_v)
    // A same-location pair leaves a bubble behind the earlier item.
    `PTIB_ASSERT_NEXT(a_hazard_bubble, i_clk, i_rst_n, hazard && en_pipe, !r_d_v && r_c_v)
    // After that bubble the waiting item takes the just-updated state.
    `PTIB_ASSERT_NEXT(a_hazard_fwd, i_clk, i_rst_n, hazard && en_pipe, fwd)
    // A finished item facing a full, stalled output register stays put.
    `PTIB_ASSERT_NEXT(a_tail_holds, i_clk, i_rst_n, r_e_v && r_o_v && !i_ready,
        r_e_v && $stable(r_e_idx))

endmodule
